// File: rtl/wpsp_pkg.sv
// ============================================================================
// wpsp_pkg
// Shared widths, register indexes, reset values and payload types of the
// world point to screen projector.
// ============================================================================
package wpsp_pkg;

    localparam int COORD_W    = 21;          // Q16.4 world coordinate
    localparam int AXIS_W     = 21;          // Q1.19 axis component
    localparam int REG_W      = 63;          // packed three-component register
    localparam int HALF_W     = 32;          // Q12.20 half extent
    localparam int VP_W       = 16;          // viewport origin / size field
    localparam int FRAC_W     = 8;           // screen fraction bits
    localparam int OFF_W      = COORD_W + 1; // point minus camera
    localparam int PROD_W     = OFF_W + AXIS_W;
    localparam int DOT_W      = PROD_W + 2;  // sum of three products, Q.23
    localparam int M_W        = 43;          // |depth| or ortho scale
    localparam int M_SPLIT    = 21;          // low slice of m for the den product
    localparam int DEN_W      = M_W + HALF_W;
    localparam int NPROD_W    = M_W + VP_W;
    localparam int NUM_SHIFT  = 20 + FRAC_W;
    localparam int NUM_W      = NPROD_W + NUM_SHIFT;
    localparam int QUO_W      = 62;          // quotient bits below the limit
    localparam int DIV_LAT    = QUO_W + 1;
    localparam int DEPTH_SH   = 19;
    localparam int DEPTH_W    = 24;
    localparam int SCR_W      = 32;
    localparam int SUM_W      = 65;
    localparam int ORTHO_SH   = 23;
    localparam int ONE_SH     = 20;          // 1.0 in Q12.20
    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;

    typedef enum logic [2:0] {
        REG_RIGHT   = 3'd0,
        REG_UP      = 3'd1,
        REG_FORWARD = 3'd2,
        REG_CAMPOS  = 3'd3,
        REG_HALF    = 3'd4,
        REG_VP_ORG  = 3'd5,
        REG_VP_SIZE = 3'd6,
        REG_MODE    = 3'd7
    } t_reg_idx;

    localparam logic [REG_W-1:0]   RST_RIGHT   = 63'd524288;
    localparam logic [REG_W-1:0]   RST_UP      = 63'd1099511627776;
    localparam logic [REG_W-1:0]   RST_FORWARD = 63'd6917529027641081856;
    localparam logic [PDATA_W-1:0] RST_HALF    = 64'd4503599628419072;

    // item state that rides beside the dividers
    typedef struct packed {
        logic                      sgn_x;
        logic                      sgn_y;
        logic                      behind;
        logic                      on;
        logic signed [DEPTH_W-1:0] depth;
    } t_side;

endpackage

// File: rtl/wpsp_in_if.sv
// ============================================================================
// wpsp_in_if
// World point channel: valid/ready with three Q16.4 coordinates.
// ============================================================================
interface wpsp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wpsp_pkg::COORD_W-1:0]  world_x;
    logic signed [wpsp_pkg::COORD_W-1:0]  world_y;
    logic signed [wpsp_pkg::COORD_W-1:0]  world_z;

    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

// File: rtl/wpsp_out_if.sv
// ============================================================================
// wpsp_out_if
// Screen point channel: valid/ready with pixel position, depth and flags.
// ============================================================================
interface wpsp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wpsp_pkg::SCR_W-1:0]    screen_x;
    logic signed [wpsp_pkg::SCR_W-1:0]    screen_y;
    logic signed [wpsp_pkg::DEPTH_W-1:0]  view_depth;
    logic                                 is_behind;
    logic                                 is_on_screen;

    modport source (output valid, screen_x, screen_y, view_depth, is_behind,
                    is_on_screen, input ready);
    modport sink   (input valid, screen_x, screen_y, view_depth, is_behind,
                    is_on_screen, output ready);
endinterface

// File: rtl/wpsp_div.sv
// ============================================================================
// wpsp_div
// Pipelined restoring divider, one quotient bit per stage, result limited
// to 2^62.
// ============================================================================
module wpsp_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [wpsp_pkg::NUM_W-1:0]     i_num,
    input  logic [wpsp_pkg::DEN_W-1:0]     i_den,
    output logic [wpsp_pkg::QUO_W:0]       o_quo
);
    logic [wpsp_pkg::DEN_W-1:0] r_rem [wpsp_pkg::QUO_W+1];
    logic [wpsp_pkg::DEN_W-1:0] r_den [wpsp_pkg::QUO_W+1];
    logic [wpsp_pkg::QUO_W-1:0] r_nlo [wpsp_pkg::QUO_W+1];
    logic [wpsp_pkg::QUO_W-1:0] r_q   [wpsp_pkg::QUO_W+1];
    logic                       r_over[wpsp_pkg::QUO_W+1];

    // stage 0: limit check and remainder seed from the top numerator bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_over[0] <= wpsp_pkg::DEN_W'(i_num[wpsp_pkg::NUM_W-1:wpsp_pkg::QUO_W]) >= i_den;
            r_rem[0]  <= wpsp_pkg::DEN_W'(i_num[wpsp_pkg::NUM_W-1:wpsp_pkg::QUO_W]);
            r_nlo[0]  <= i_num[wpsp_pkg::QUO_W-1:0];
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
        end
    end

    for (genvar k = 1; k <= wpsp_pkg::QUO_W; k++) begin : g_stage
        logic [wpsp_pkg::DEN_W:0] n_sh;
        logic [wpsp_pkg::DEN_W:0] n_diff;
        logic                     n_ge;

        always_comb begin
            n_sh   = {r_rem[k-1], r_nlo[k-1][wpsp_pkg::QUO_W-1]};
            n_diff = n_sh - {1'b0, r_den[k-1]};
            n_ge   = n_sh >= {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? n_diff[wpsp_pkg::DEN_W-1:0] : n_sh[wpsp_pkg::DEN_W-1:0];
                r_nlo[k]  <= {r_nlo[k-1][wpsp_pkg::QUO_W-2:0], 1'b0};
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= {r_q[k-1][wpsp_pkg::QUO_W-2:0], n_ge};
                r_over[k] <= r_over[k-1];
            end
        end
    end

    assign o_quo = r_over[wpsp_pkg::QUO_W] ? {1'b1, {wpsp_pkg::QUO_W{1'b0}}}
                                           : {1'b0, r_q[wpsp_pkg::QUO_W]};
endmodule

// File: rtl/world_point_to_screen_projector.sv
// ============================================================================
// world_point_to_screen_projector
// Projects a world point to viewport pixels through a configurable camera,
// perspective or orthographic, in a fully pipelined datapath.
// ============================================================================
//
//  channel   dir  handshake        payload
//  i_pt      in   valid / ready    world_x, world_y, world_z (Q16.4)
//  o_scr     out  valid / ready    screen_x, screen_y (Q23.8), view_depth,
//                                  is_behind, is_on_screen
//  apb       in   psel / penable   paddr[5:3] = register, pwdata 64 bits
//
//  One point per cycle unless the output stalls. The pipe holds 6 stages
//  of offset, dot product, depth select, products and operand assembly,
//  63 divider stages (one quotient bit per stage, two dividers side by
//  side) and one output stage. Synchronous active-low reset clears the
//  valid bits; registers return to the default camera. A stalled output
//  freezes the whole pipe; nothing is dropped or repeated, and a new
//  transaction is taken when the last stage is empty or being drained.
//
module world_point_to_screen_projector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wpsp_in_if.sink                         i_pt,
    wpsp_out_if.source                      o_scr,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wpsp_pkg::PADDR_W-1:0]    paddr,
    input  logic [wpsp_pkg::PDATA_W-1:0]    pwdata,
    output logic [wpsp_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    localparam int NSTG = 6 + wpsp_pkg::DIV_LAT + 1;

    // ---------------- configuration registers ----------------
    logic [wpsp_pkg::REG_W-1:0]   r_right, r_up, r_fwd, r_cam;
    logic [wpsp_pkg::PDATA_W-1:0] r_half;
    logic [2*wpsp_pkg::VP_W-1:0]  r_org, r_size;
    logic                         r_ortho;
    wpsp_pkg::t_reg_idx           w_idx;

    assign w_idx  = wpsp_pkg::t_reg_idx'(paddr[wpsp_pkg::PADDR_W-1:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= wpsp_pkg::RST_RIGHT;
            r_up    <= wpsp_pkg::RST_UP;
            r_fwd   <= wpsp_pkg::RST_FORWARD;
            r_cam   <= '0;
            r_half  <= wpsp_pkg::RST_HALF;
            r_org   <= '0;
            r_size  <= '0;
            r_ortho <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                wpsp_pkg::REG_RIGHT:   r_right <= pwdata[wpsp_pkg::REG_W-1:0];
                wpsp_pkg::REG_UP:      r_up    <= pwdata[wpsp_pkg::REG_W-1:0];
                wpsp_pkg::REG_FORWARD: r_fwd   <= pwdata[wpsp_pkg::REG_W-1:0];
                wpsp_pkg::REG_CAMPOS:  r_cam   <= pwdata[wpsp_pkg::REG_W-1:0];
                wpsp_pkg::REG_HALF:    r_half  <= pwdata;
                wpsp_pkg::REG_VP_ORG:  r_org   <= pwdata[2*wpsp_pkg::VP_W-1:0];
                wpsp_pkg::REG_VP_SIZE: r_size  <= pwdata[2*wpsp_pkg::VP_W-1:0];
                wpsp_pkg::REG_MODE:    r_ortho <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            wpsp_pkg::REG_RIGHT:   prdata = {1'b0, r_right};
            wpsp_pkg::REG_UP:      prdata = {1'b0, r_up};
            wpsp_pkg::REG_FORWARD: prdata = {1'b0, r_fwd};
            wpsp_pkg::REG_CAMPOS:  prdata = {1'b0, r_cam};
            wpsp_pkg::REG_HALF:    prdata = r_half;
            wpsp_pkg::REG_VP_ORG:  prdata = wpsp_pkg::PDATA_W'(r_org);
            wpsp_pkg::REG_VP_SIZE: prdata = wpsp_pkg::PDATA_W'(r_size);
            wpsp_pkg::REG_MODE:    prdata = wpsp_pkg::PDATA_W'(r_ortho);
            default:               prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] r_vld;
    logic            w_en;

    assign w_en       = !r_vld[NSTG-1] || o_scr.ready;
    assign i_pt.ready = w_en;
    assign o_scr.valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pt.valid};
        end
    end

    // ---------------- S1: offset from camera ----------------
    logic signed [wpsp_pkg::COORD_W-1:0] w_world [3];
    logic signed [wpsp_pkg::OFF_W-1:0]   n1_off  [3];
    logic signed [wpsp_pkg::OFF_W-1:0]   r1_off  [3];

    assign w_world[0] = i_pt.world_x;
    assign w_world[1] = i_pt.world_y;
    assign w_world[2] = i_pt.world_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_off[k] = wpsp_pkg::OFF_W'(w_world[k])
                      - wpsp_pkg::OFF_W'($signed(r_cam[k*wpsp_pkg::COORD_W +: wpsp_pkg::COORD_W]));
        end
    end

    // ---------------- S2: nine products (row 0 forward, 1 right, 2 up) ----------------
    logic [wpsp_pkg::REG_W-1:0]         w_axis  [3];
    logic signed [wpsp_pkg::PROD_W-1:0] r2_prod [3][3];

    assign w_axis[0] = r_fwd;
    assign w_axis[1] = r_right;
    assign w_axis[2] = r_up;

    // ---------------- S3: dot products, Q.23 ----------------
    logic signed [wpsp_pkg::DOT_W-1:0]  r3_dot [3];

    // ---------------- S4: depth select ----------------
    logic signed [wpsp_pkg::DOT_W-1:0]  w_dq, w_adq, w_ax, w_ay;
    logic signed [wpsp_pkg::DOT_W-wpsp_pkg::DEPTH_SH-1:0] w_dsh;
    logic [wpsp_pkg::M_W-1:0]           n4_m;
    wpsp_pkg::t_side                    n4_side;
    logic [wpsp_pkg::M_W-1:0]           r4_m, r4_magx, r4_magy;
    wpsp_pkg::t_side                    r4_side;

    always_comb begin
        w_dq  = r3_dot[0];
        w_adq = w_dq[wpsp_pkg::DOT_W-1] ? -w_dq : w_dq;
        w_ax  = r3_dot[1][wpsp_pkg::DOT_W-1] ? -r3_dot[1] : r3_dot[1];
        w_ay  = r3_dot[2][wpsp_pkg::DOT_W-1] ? -r3_dot[2] : r3_dot[2];
        // floor(depth / 2^19): drop the low bits, keep the sign
        w_dsh = w_dq[wpsp_pkg::DOT_W-1:wpsp_pkg::DEPTH_SH];
        if (r_ortho) begin
            n4_m = wpsp_pkg::M_W'(1) << wpsp_pkg::ORTHO_SH;
        end else if (w_dq == '0) begin
            n4_m = wpsp_pkg::M_W'(1);    // zero depth counts as one LSB
        end else begin
            n4_m = w_adq[wpsp_pkg::M_W-1:0];
        end
        n4_side.sgn_x  = r3_dot[1][wpsp_pkg::DOT_W-1];
        n4_side.sgn_y  = r3_dot[2][wpsp_pkg::DOT_W-1];
        n4_side.behind = r_ortho ? w_dq[wpsp_pkg::DOT_W-1]
                                 : (w_dq[wpsp_pkg::DOT_W-1] || w_dq == '0);
        n4_side.on     = 1'b0;
        // saturate floor(depth / 2^19) into 24 bits
        if (&w_dsh[$left(w_dsh):wpsp_pkg::DEPTH_W-1] || ~|w_dsh[$left(w_dsh):wpsp_pkg::DEPTH_W-1])
        begin
            n4_side.depth = w_dsh[wpsp_pkg::DEPTH_W-1:0];
        end else begin
            n4_side.depth = w_dsh[$left(w_dsh)] ? {1'b1, {(wpsp_pkg::DEPTH_W-1){1'b0}}}
                                                : {1'b0, {(wpsp_pkg::DEPTH_W-1){1'b1}}};
        end
    end

    // ---------------- S5: partial products ----------------
    logic [wpsp_pkg::HALF_W-1:0] w_hx, w_hy;
    logic [wpsp_pkg::M_W-wpsp_pkg::M_SPLIT+wpsp_pkg::HALF_W-1:0] r5_dx_hi, r5_dy_hi;
    logic [wpsp_pkg::M_SPLIT+wpsp_pkg::HALF_W-1:0]               r5_dx_lo, r5_dy_lo;
    logic [wpsp_pkg::NPROD_W-1:0] r5_nx, r5_ny;
    logic [wpsp_pkg::M_W-1:0]     r5_magx, r5_magy;
    wpsp_pkg::t_side              r5_side;

    // zero half extent reads as 1.0
    assign w_hx = (r_half[wpsp_pkg::HALF_W-1:0] == '0)
                ? wpsp_pkg::HALF_W'(1) << wpsp_pkg::ONE_SH : r_half[wpsp_pkg::HALF_W-1:0];
    assign w_hy = (r_half[2*wpsp_pkg::HALF_W-1:wpsp_pkg::HALF_W] == '0)
                ? wpsp_pkg::HALF_W'(1) << wpsp_pkg::ONE_SH
                : r_half[2*wpsp_pkg::HALF_W-1:wpsp_pkg::HALF_W];

    // ---------------- S6: numerator and denominator ----------------
    logic [wpsp_pkg::DEN_W-1:0]   r6_den_x, r6_den_y;
    logic [wpsp_pkg::NUM_W-1:0]   r6_num_x, r6_num_y;
    logic [wpsp_pkg::M_W-1:0]     r6_magx, r6_magy;
    wpsp_pkg::t_side              r6_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_off <= n1_off;
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_prod[a][k] <= wpsp_pkg::PROD_W'(r1_off[k])
                        * wpsp_pkg::PROD_W'($signed(w_axis[a][k*wpsp_pkg::AXIS_W +: wpsp_pkg::AXIS_W]));
                end
                r3_dot[a] <= wpsp_pkg::DOT_W'(r2_prod[a][0]) + wpsp_pkg::DOT_W'(r2_prod[a][1])
                           + wpsp_pkg::DOT_W'(r2_prod[a][2]);
            end
            r4_m    <= n4_m;
            r4_magx <= w_ax[wpsp_pkg::M_W-1:0];
            r4_magy <= w_ay[wpsp_pkg::M_W-1:0];
            r4_side <= n4_side;

            r5_dx_hi <= r4_m[wpsp_pkg::M_W-1:wpsp_pkg::M_SPLIT] * w_hx;
            r5_dx_lo <= r4_m[wpsp_pkg::M_SPLIT-1:0] * w_hx;
            r5_dy_hi <= r4_m[wpsp_pkg::M_W-1:wpsp_pkg::M_SPLIT] * w_hy;
            r5_dy_lo <= r4_m[wpsp_pkg::M_SPLIT-1:0] * w_hy;
            r5_nx    <= r4_magx * r_size[wpsp_pkg::VP_W-1:0];
            r5_ny    <= r4_magy * r_size[2*wpsp_pkg::VP_W-1:wpsp_pkg::VP_W];
            r5_magx  <= r4_magx;
            r5_magy  <= r4_magy;
            r5_side  <= r4_side;

            r6_den_x <= {r5_dx_hi, {wpsp_pkg::M_SPLIT{1'b0}}} + wpsp_pkg::DEN_W'(r5_dx_lo);
            r6_den_y <= {r5_dy_hi, {wpsp_pkg::M_SPLIT{1'b0}}} + wpsp_pkg::DEN_W'(r5_dy_lo);
            r6_num_x <= {r5_nx, {wpsp_pkg::NUM_SHIFT{1'b0}}};
            r6_num_y <= {r5_ny, {wpsp_pkg::NUM_SHIFT{1'b0}}};
            r6_magx  <= r5_magx;
            r6_magy  <= r5_magy;
            r6_side  <= r5_side;
        end
    end

    // ---------------- dividers and side line ----------------
    logic [wpsp_pkg::QUO_W:0] w_qx, w_qy;
    wpsp_pkg::t_side          n_line0;
    wpsp_pkg::t_side          r_line [wpsp_pkg::DIV_LAT];

    wpsp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_num_x),
        .i_den (r6_den_x),
        .o_quo (w_qx)
    );

    wpsp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_num_y),
        .i_den (r6_den_y),
        .o_quo (w_qy)
    );

    // on screen: in front and |lateral| * 2^20 <= den on both axes
    always_comb begin
        n_line0    = r6_side;
        n_line0.on = !r6_side.behind
                  && (wpsp_pkg::DEN_W'({r6_magx, {wpsp_pkg::ONE_SH{1'b0}}}) <= r6_den_x)
                  && (wpsp_pkg::DEN_W'({r6_magy, {wpsp_pkg::ONE_SH{1'b0}}}) <= r6_den_y);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_line[0] <= n_line0;
            for (int s = 1; s < wpsp_pkg::DIV_LAT; s++) begin
                r_line[s] <= r_line[s-1];
            end
        end
    end

    // ---------------- output stage ----------------
    function automatic logic signed [wpsp_pkg::SCR_W-1:0] sat_scr(
        input logic signed [wpsp_pkg::SUM_W-1:0] v
    );
        logic signed [wpsp_pkg::SUM_W-1:0] h;
        h = v >>> 1;
        if (&h[wpsp_pkg::SUM_W-1:wpsp_pkg::SCR_W-1] || ~|h[wpsp_pkg::SUM_W-1:wpsp_pkg::SCR_W-1])
            return h[wpsp_pkg::SCR_W-1:0];
        return h[wpsp_pkg::SUM_W-1] ? {1'b1, {(wpsp_pkg::SCR_W-1){1'b0}}}
                                    : {1'b0, {(wpsp_pkg::SCR_W-1){1'b1}}};
    endfunction

    wpsp_pkg::t_side                      w_tail;
    logic [wpsp_pkg::VP_W+1:0]            w_bx, w_by;
    logic signed [wpsp_pkg::SUM_W-1:0]    w_sx, w_sy, w_ox, w_oy;
    logic signed [wpsp_pkg::SCR_W-1:0]    r_sx, r_sy;
    logic signed [wpsp_pkg::DEPTH_W-1:0]  r_depth;
    logic                                 r_behind, r_on;

    always_comb begin
        w_tail = r_line[wpsp_pkg::DIV_LAT-1];
        // twice the viewport center, in pixels (needs two bits above a field)
        w_bx = {1'b0, r_org[wpsp_pkg::VP_W-1:0], 1'b0}
             + {2'b00, r_size[wpsp_pkg::VP_W-1:0]};
        w_by = {1'b0, r_org[2*wpsp_pkg::VP_W-1:wpsp_pkg::VP_W], 1'b0}
             + {2'b00, r_size[2*wpsp_pkg::VP_W-1:wpsp_pkg::VP_W]};
        w_ox = w_tail.sgn_x ? -$signed(wpsp_pkg::SUM_W'(w_qx)) : $signed(wpsp_pkg::SUM_W'(w_qx));
        w_oy = w_tail.sgn_y ? -$signed(wpsp_pkg::SUM_W'(w_qy)) : $signed(wpsp_pkg::SUM_W'(w_qy));
        w_sx = $signed(wpsp_pkg::SUM_W'({w_bx, {wpsp_pkg::FRAC_W{1'b0}}})) + w_ox;
        w_sy = $signed(wpsp_pkg::SUM_W'({w_by, {wpsp_pkg::FRAC_W{1'b0}}})) - w_oy;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx     <= sat_scr(w_sx);
            r_sy     <= sat_scr(w_sy);
            r_depth  <= w_tail.depth;
            r_behind <= w_tail.behind;
            r_on     <= w_tail.on;
        end
    end

    assign o_scr.screen_x     = r_sx;
    assign o_scr.screen_y     = r_sy;
    assign o_scr.view_depth   = r_depth;
    assign o_scr.is_behind    = r_behind;
    assign o_scr.is_on_screen = r_on;

    // ---------------- assertions ----------------
    a_on_not_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_scr.valid |-> !(o_scr.is_on_screen && o_scr.is_behind))
        else $error("on-screen point flagged behind");

    a_neg_depth_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_scr.valid && o_scr.view_depth[wpsp_pkg::DEPTH_W-1] |-> o_scr.is_behind)
        else $error("negative depth not flagged behind");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.valid && i_pt.ready |=> r_vld[0])
        else $error("accepted transaction lost at pipe entry");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_scr.valid)
        else $error("output valid right after reset");

endmodule
